// ===== rtl/vertex_perspective_projection_unit_defines.svh =====
// Assertion macros shared by the view queue and the back part.
// Each use needs clk and rst_n in scope.
`ifndef VERTEX_PERSPECTIVE_PROJECTION_UNIT_DEFINES_SVH
`define VERTEX_PERSPECTIVE_PROJECTION_UNIT_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define VPP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause.
`define VPP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/vpp_pkg.sv =====
package vpp_pkg;

    // Port and register widths
    localparam int WORLD_W   = 32;
    localparam int ROT_W     = 16;
    localparam int FOC_W     = 32;
    localparam int SCR_W     = 32;
    localparam int DEPTH_W   = 31;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    // Rotation datapath widths
    localparam int DIFF_W  = WORLD_W + 1;
    localparam int UQ_W    = ROT_W + 1;
    localparam int FRAC_W  = 14;
    localparam int PA_W    = UQ_W + DIFF_W;
    localparam int TD_W    = PA_W + 1;
    localparam int T_SH    = FRAC_W - 1;
    localparam int T_W     = TD_W - T_SH;
    localparam int PB_W    = UQ_W + T_W;
    localparam int ACC_W   = PB_W + 2;
    localparam int VIEW_W  = ACC_W - FRAC_W;

    // Projection datapath widths
    localparam int DIV_W   = VIEW_W;
    localparam int QB_W    = 34;
    localparam int MAG_LO_W = 32;
    localparam int PLO_W   = MAG_LO_W + FOC_W;
    localparam int PHI_W   = DIV_W - MAG_LO_W + FOC_W;
    localparam int NUM_W   = DIV_W + FOC_W;
    localparam int SUM_W   = QB_W + 3;
    localparam int HI_W    = NUM_W - QB_W;

    // Projection pipeline depth: sign split, multiply, dividend, one stage per quotient bit
    localparam int B_STG   = QB_W + 3;

    // Screen geometry and constants
    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;
    localparam int HALF_SCALE    = 32768;
    localparam int DEPTH_MIN     = 66;
    localparam logic signed [SUM_W-1:0] HALF_X = SUM_W'(SCREEN_WIDTH * HALF_SCALE);
    localparam logic signed [SUM_W-1:0] HALF_Y = SUM_W'(SCREEN_HEIGHT * HALF_SCALE);
    localparam logic signed [SCR_W-1:0] SCR_MAX = {1'b0, {(SCR_W-1){1'b1}}};
    localparam logic signed [SCR_W-1:0] SCR_MIN = {1'b1, {(SCR_W-1){1'b0}}};

    // Queue between front and back
    localparam int MQ_DEPTH = 4;
    localparam int MQ_PTR_W = 2;
    localparam int MQ_CNT_W = 3;

    // Output queue of the back part
    localparam int OQ_DEPTH = 2;
    localparam int OQ_PTR_W = 1;
    localparam int OQ_CNT_W = 2;

    // Register reset values
    localparam logic [WORLD_W-1:0] CAM_RESET   = '0;
    localparam logic [ROT_W-1:0]   ROT_W_RESET = 16'd16384;
    localparam logic [ROT_W-1:0]   ROT_RESET   = '0;
    localparam logic [FOC_W-1:0]   FOC_RESET   = 32'd8388608;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAM_X,
        REG_CAM_Y,
        REG_CAM_Z,
        REG_ROT_W,
        REG_ROT_X,
        REG_ROT_Y,
        REG_ROT_Z,
        REG_FOCAL
    } cfg_reg_t;

    typedef struct packed {
        logic signed [WORLD_W-1:0] cam_x;
        logic signed [WORLD_W-1:0] cam_y;
        logic signed [WORLD_W-1:0] cam_z;
        logic signed [ROT_W-1:0]   rot_w;
        logic signed [ROT_W-1:0]   rot_x;
        logic signed [ROT_W-1:0]   rot_y;
        logic signed [ROT_W-1:0]   rot_z;
    } cam_cfg_t;

    typedef struct packed {
        logic signed [VIEW_W-1:0] x;
        logic signed [VIEW_W-1:0] y;
        logic signed [VIEW_W-1:0] z;
    } view_t;

endpackage

// ===== rtl/vpp_front.sv =====
module vpp_front
    import vpp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic signed [WORLD_W-1:0] world_x,
    input  logic signed [WORLD_W-1:0] world_y,
    input  logic signed [WORLD_W-1:0] world_z,
    input  cam_cfg_t                  cfg,
    output logic                      q_wr,
    output view_t                     q_data,
    input  logic                      q_full
);

    logic [3:0] vld_reg;
    logic [3:0] vld_next;
    logic       en;
    logic       acc;

    logic signed [UQ_W-1:0] uw;
    logic signed [UQ_W-1:0] ux;
    logic signed [UQ_W-1:0] uy;
    logic signed [UQ_W-1:0] uz;

    logic signed [DIFF_W-1:0] r0_reg [3];
    logic signed [DIFF_W-1:0] r1_reg [3];
    logic signed [DIFF_W-1:0] r2_reg [3];
    logic signed [DIFF_W-1:0] r3_reg [3];
    logic signed [DIFF_W-1:0] r_next [3];
    logic signed [PA_W-1:0]   pa_reg [6];
    logic signed [PA_W-1:0]   pa_next [6];
    logic signed [TD_W-1:0]   td [3];
    logic signed [T_W-1:0]    t_reg [3];
    logic signed [PB_W-1:0]   pb_reg [9];
    logic signed [PB_W-1:0]   pb_next [9];
    logic signed [ACC_W-1:0]  sum [3];

    // Advance the whole pipeline unless the last stage is blocked
    assign en   = !(vld_reg[3] && q_full);
    assign full = !en;
    assign acc  = push && en;
    assign q_wr = vld_reg[3] && en;

    // Conjugate vector part and scalar part, widened
    assign uw = {cfg.rot_w[ROT_W-1], cfg.rot_w};
    assign ux = -{cfg.rot_x[ROT_W-1], cfg.rot_x};
    assign uy = -{cfg.rot_y[ROT_W-1], cfg.rot_y};
    assign uz = -{cfg.rot_z[ROT_W-1], cfg.rot_z};

    // Advance valid bits
    always_comb
    begin
        vld_next = vld_reg;
        if (en)
        begin
            vld_next = {vld_reg[2:0], acc};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Form the vertex offset from the camera
    always_comb
    begin
        r_next[0] = {world_x[WORLD_W-1], world_x} - {cfg.cam_x[WORLD_W-1], cfg.cam_x};
        r_next[1] = {world_y[WORLD_W-1], world_y} - {cfg.cam_y[WORLD_W-1], cfg.cam_y};
        r_next[2] = {world_z[WORLD_W-1], world_z} - {cfg.cam_z[WORLD_W-1], cfg.cam_z};
    end

    // Cross product terms of u x r
    always_comb
    begin
        pa_next[0] = uy * r0_reg[2];
        pa_next[1] = uz * r0_reg[1];
        pa_next[2] = uz * r0_reg[0];
        pa_next[3] = ux * r0_reg[2];
        pa_next[4] = ux * r0_reg[1];
        pa_next[5] = uy * r0_reg[0];
    end

    // Double and floor to Q.16
    always_comb
    begin
        td[0] = {pa_reg[0][PA_W-1], pa_reg[0]} - {pa_reg[1][PA_W-1], pa_reg[1]};
        td[1] = {pa_reg[2][PA_W-1], pa_reg[2]} - {pa_reg[3][PA_W-1], pa_reg[3]};
        td[2] = {pa_reg[4][PA_W-1], pa_reg[4]} - {pa_reg[5][PA_W-1], pa_reg[5]};
    end

    // Products with t: w*t and u x t
    always_comb
    begin
        pb_next[0] = uw * t_reg[0];
        pb_next[1] = uw * t_reg[1];
        pb_next[2] = uw * t_reg[2];
        pb_next[3] = uy * t_reg[2];
        pb_next[4] = uz * t_reg[1];
        pb_next[5] = uz * t_reg[0];
        pb_next[6] = ux * t_reg[2];
        pb_next[7] = ux * t_reg[1];
        pb_next[8] = uy * t_reg[0];
    end

    // Sum the view components and floor to Q.16
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum[i] = {{(ACC_W-DIFF_W-FRAC_W){r3_reg[i][DIFF_W-1]}}, r3_reg[i],
                      {FRAC_W{1'b0}}}
                   + {{(ACC_W-PB_W){pb_reg[i][PB_W-1]}}, pb_reg[i]}
                   + {{(ACC_W-PB_W){pb_reg[3+2*i][PB_W-1]}}, pb_reg[3+2*i]}
                   - {{(ACC_W-PB_W){pb_reg[4+2*i][PB_W-1]}}, pb_reg[4+2*i]};
        end
        q_data.x = sum[0][ACC_W-1:FRAC_W];
        q_data.y = sum[1][ACC_W-1:FRAC_W];
        q_data.z = sum[2][ACC_W-1:FRAC_W];
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                r0_reg[i] <= r_next[i];
                r1_reg[i] <= r0_reg[i];
                r2_reg[i] <= r1_reg[i];
                r3_reg[i] <= r2_reg[i];
                t_reg[i]  <= td[i][TD_W-1:T_SH];
            end
            for (int i = 0; i < 6; i++)
            begin
                pa_reg[i] <= pa_next[i];
            end
            for (int i = 0; i < 9; i++)
            begin
                pb_reg[i] <= pb_next[i];
            end
        end
    end

endmodule

// ===== rtl/vpp_queue.sv =====
module vpp_queue
    import vpp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr,
    input  view_t wr_data,
    output logic  full,
    input  logic  rd,
    output view_t rd_data,
    output logic  empty
);

    `include "vertex_perspective_projection_unit_defines.svh"

    view_t                mem [MQ_DEPTH];
    logic [MQ_PTR_W-1:0] wr_ptr_reg;
    logic [MQ_PTR_W-1:0] wr_ptr_next;
    logic [MQ_PTR_W-1:0] rd_ptr_reg;
    logic [MQ_PTR_W-1:0] rd_ptr_next;
    logic [MQ_CNT_W-1:0] count_reg;
    logic [MQ_CNT_W-1:0] count_next;

    assign full    = (count_reg == MQ_CNT_W'(MQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (rd)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (wr && !rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store incoming views
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    `VPP_ASSERT_NOW(a_mq_no_overflow, wr, !full || rd, "view queue written while full")
    `VPP_ASSERT_NOW(a_mq_no_underflow, rd, !empty, "view queue read while empty")
    `VPP_ASSERT_NEXT(a_mq_count_up, wr && !rd, count_reg == $past(count_reg) + 1'b1,
                     "view queue count did not grow on write")

endmodule

// ===== rtl/vpp_back.sv =====
module vpp_back
    import vpp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  view_t                     in_data,
    output logic                      in_rd,
    input  logic [FOC_W-1:0]          focal,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [SCR_W-1:0]   screen_x,
    output logic signed [SCR_W-1:0]   screen_y,
    output logic [DEPTH_W-1:0]        depth_z,
    output logic                      saturated
);

    `include "vertex_perspective_projection_unit_defines.svh"

    typedef struct packed {
        logic               negx;
        logic               negy;
        logic [DIV_W-1:0]   magx;
        logic [DIV_W-1:0]   magy;
        logic [DIV_W-1:0]   z;
        logic [DEPTH_W-1:0] dz;
        logic               dflag;
    } b0_t;

    typedef struct packed {
        logic               negx;
        logic               negy;
        logic [PLO_W-1:0]   p0x;
        logic [PHI_W-1:0]   p1x;
        logic [PLO_W-1:0]   p0y;
        logic [PHI_W-1:0]   p1y;
        logic [DIV_W-1:0]   z;
        logic [DEPTH_W-1:0] dz;
        logic               dflag;
    } b1_t;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [QB_W-1:0]  nlow;
        logic [QB_W-1:0]  quo;
        logic             neg;
        logic             ovf;
    } div_lane_t;

    typedef struct packed {
        div_lane_t          lx;
        div_lane_t          ly;
        logic [DIV_W-1:0]   z;
        logic [DEPTH_W-1:0] dz;
        logic               dflag;
    } div_t;

    typedef struct packed {
        logic signed [SCR_W-1:0] val;
        logic                    flag;
    } coord_t;

    typedef struct packed {
        logic signed [SCR_W-1:0] sx;
        logic signed [SCR_W-1:0] sy;
        logic [DEPTH_W-1:0]      dz;
        logic                    sat;
    } result_t;

    // One restoring division step on one lane
    function automatic div_lane_t lane_step(div_lane_t l, logic [DIV_W-1:0] d);
        logic [DIV_W:0] rsh;
        div_lane_t      o;
        rsh = {l.rem, l.nlow[QB_W-1]};
        o = l;
        o.nlow = {l.nlow[QB_W-2:0], 1'b0};
        if (rsh >= {1'b0, d})
        begin
            o.rem = DIV_W'(rsh - {1'b0, d});
            o.quo = {l.quo[QB_W-2:0], 1'b1};
        end
        else
        begin
            o.rem = rsh[DIV_W-1:0];
            o.quo = {l.quo[QB_W-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic div_t stage_step(div_t s);
        div_t o;
        o = s;
        o.lx = lane_step(s.lx, s.z);
        o.ly = lane_step(s.ly, s.z);
        return o;
    endfunction

    // Start a lane from the full product
    function automatic div_lane_t lane_init(logic [PLO_W-1:0] p0, logic [PHI_W-1:0] p1,
                                            logic neg, logic [DIV_W-1:0] d);
        logic [NUM_W-1:0] num;
        logic [DIV_W-1:0] hi;
        div_lane_t        o;
        num = {{(NUM_W-PLO_W){1'b0}}, p0} + {p1, {MAG_LO_W{1'b0}}};
        hi = {{(DIV_W-HI_W){1'b0}}, num[NUM_W-1:QB_W]};
        o.rem  = hi;
        o.nlow = num[QB_W-1:0];
        o.quo  = '0;
        o.neg  = neg;
        o.ovf  = (hi >= d);
        return o;
    endfunction

    // Restore sign, add screen center, saturate
    function automatic coord_t lane_final(div_lane_t l, logic signed [SUM_W-1:0] half);
        logic signed [SUM_W-1:0] qe;
        logic signed [SUM_W-1:0] s;
        coord_t                  o;
        qe = $signed({{(SUM_W-QB_W){1'b0}}, l.quo});
        s  = l.neg ? half - qe : half + qe;
        if (l.ovf)
        begin
            o.val  = l.neg ? SCR_MIN : SCR_MAX;
            o.flag = 1'b1;
        end
        else if (s[SUM_W-1:SCR_W-1] != {(SUM_W-SCR_W+1){s[SUM_W-1]}})
        begin
            o.val  = s[SUM_W-1] ? SCR_MIN : SCR_MAX;
            o.flag = 1'b1;
        end
        else
        begin
            o.val  = s[SCR_W-1:0];
            o.flag = 1'b0;
        end
        return o;
    endfunction

    logic [B_STG-1:0] vld_reg;
    logic [B_STG-1:0] vld_next;
    logic             en;

    b0_t  b0_reg;
    b0_t  b0_next;
    b1_t  b1_reg;
    b1_t  b1_next;
    div_t dv_reg [QB_W+1];
    div_t dv_init;

    logic signed [VIEW_W-1:0] vx;
    logic signed [VIEW_W-1:0] vy;
    logic signed [VIEW_W-1:0] vz;
    logic [DIV_W-1:0]         zc;

    coord_t  cx;
    coord_t  cy;
    result_t res;

    result_t             oq_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] oq_wr_ptr_reg;
    logic [OQ_PTR_W-1:0] oq_wr_ptr_next;
    logic [OQ_PTR_W-1:0] oq_rd_ptr_reg;
    logic [OQ_PTR_W-1:0] oq_rd_ptr_next;
    logic [OQ_CNT_W-1:0] oq_count_reg;
    logic [OQ_CNT_W-1:0] oq_count_next;
    logic    oq_full;
    logic    oq_wr;
    logic    oq_rd;

    // Stall only when the finished item has no room in the output queue
    assign oq_full = (oq_count_reg == OQ_CNT_W'(OQ_DEPTH));
    assign en      = !(vld_reg[B_STG-1] && oq_full);
    assign in_rd   = en && in_valid;
    assign oq_wr   = vld_reg[B_STG-1] && en;
    assign empty   = (oq_count_reg == '0);
    assign oq_rd   = pop && !empty;

    always_comb
    begin
        vld_next = vld_reg;
        if (en)
        begin
            vld_next = {vld_reg[B_STG-2:0], in_valid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Split signs, clamp the depth
    always_comb
    begin
        vx = in_data.x;
        vy = in_data.y;
        vz = in_data.z;
        if (vz < $signed(VIEW_W'(DEPTH_MIN)))
        begin
            zc = DIV_W'(DEPTH_MIN);
        end
        else
        begin
            zc = vz;
        end
        b0_next.negx = vx[VIEW_W-1];
        b0_next.negy = vy[VIEW_W-1];
        b0_next.magx = vx[VIEW_W-1] ? -vx : vx;
        b0_next.magy = vy[VIEW_W-1] ? -vy : vy;
        b0_next.z    = zc;
        if (|zc[DIV_W-1:DEPTH_W])
        begin
            b0_next.dz    = '1;
            b0_next.dflag = 1'b1;
        end
        else
        begin
            b0_next.dz    = zc[DEPTH_W-1:0];
            b0_next.dflag = 1'b0;
        end
    end

    // Partial products of magnitude times focal scale
    always_comb
    begin
        b1_next.negx  = b0_reg.negx;
        b1_next.negy  = b0_reg.negy;
        b1_next.p0x   = b0_reg.magx[MAG_LO_W-1:0] * focal;
        b1_next.p1x   = b0_reg.magx[DIV_W-1:MAG_LO_W] * focal;
        b1_next.p0y   = b0_reg.magy[MAG_LO_W-1:0] * focal;
        b1_next.p1y   = b0_reg.magy[DIV_W-1:MAG_LO_W] * focal;
        b1_next.z     = b0_reg.z;
        b1_next.dz    = b0_reg.dz;
        b1_next.dflag = b0_reg.dflag;
    end

    // Form the dividends and check for quotient overflow
    always_comb
    begin
        dv_init.lx    = lane_init(b1_reg.p0x, b1_reg.p1x, b1_reg.negx, b1_reg.z);
        dv_init.ly    = lane_init(b1_reg.p0y, b1_reg.p1y, b1_reg.negy, b1_reg.z);
        dv_init.z     = b1_reg.z;
        dv_init.dz    = b1_reg.dz;
        dv_init.dflag = b1_reg.dflag;
    end

    // Pipeline payload: one quotient bit per stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b0_reg    <= b0_next;
            b1_reg    <= b1_next;
            dv_reg[0] <= dv_init;
            for (int k = 0; k < QB_W; k++)
            begin
                dv_reg[k+1] <= stage_step(dv_reg[k]);
            end
        end
    end

    // Finish the result
    always_comb
    begin
        cx = lane_final(dv_reg[QB_W].lx, HALF_X);
        cy = lane_final(dv_reg[QB_W].ly, HALF_Y);
        res.sx  = cx.val;
        res.sy  = cy.val;
        res.dz  = dv_reg[QB_W].dz;
        res.sat = cx.flag || cy.flag || dv_reg[QB_W].dflag;
    end

    // Output queue control
    always_comb
    begin
        oq_wr_ptr_next = oq_wr_ptr_reg;
        oq_rd_ptr_next = oq_rd_ptr_reg;
        oq_count_next  = oq_count_reg;
        if (oq_wr)
        begin
            oq_wr_ptr_next = oq_wr_ptr_reg + 1'b1;
        end
        if (oq_rd)
        begin
            oq_rd_ptr_next = oq_rd_ptr_reg + 1'b1;
        end
        if (oq_wr && !oq_rd)
        begin
            oq_count_next = oq_count_reg + 1'b1;
        end
        else if (oq_rd && !oq_wr)
        begin
            oq_count_next = oq_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_count_reg  <= '0;
        end
        else
        begin
            oq_wr_ptr_reg <= oq_wr_ptr_next;
            oq_rd_ptr_reg <= oq_rd_ptr_next;
            oq_count_reg  <= oq_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_wr)
        begin
            oq_mem[oq_wr_ptr_reg] <= res;
        end
    end

    assign screen_x  = oq_mem[oq_rd_ptr_reg].sx;
    assign screen_y  = oq_mem[oq_rd_ptr_reg].sy;
    assign depth_z   = oq_mem[oq_rd_ptr_reg].dz;
    assign saturated = oq_mem[oq_rd_ptr_reg].sat;

    `VPP_ASSERT_NOW(a_bk_depth_floor, !empty, depth_z >= DEPTH_W'(DEPTH_MIN),
                    "result depth below the near clamp")
    `VPP_ASSERT_NOW(a_bk_oq_room, oq_wr, oq_count_reg != OQ_CNT_W'(OQ_DEPTH),
                    "output queue written while full")
    `VPP_ASSERT_NEXT(a_bk_stall_hold, !en, vld_reg == $past(vld_reg),
                     "projection pipeline moved while stalled")

endmodule

// ===== rtl/vertex_perspective_projection_unit.sv =====
// Channel   Handshake           Payload
// ------    ---------           -------
// input     push / full         world_x, world_y, world_z
// result    pop / empty         screen_x, screen_y, depth_z, saturated
// config    cfg_wr_en           cfg_index, cfg_data
//
// One vertex per cycle sustained while results are popped; every stage of both pipelines is full rate.
// A vertex passes the rotation pipeline, the view queue, then the projection
// pipeline with its 34-step restoring divider, and last the output queue.
// Reset clears valid bits, queue pointers and loads the register defaults.
// A full output queue stalls the projection pipeline; a full view queue
// stalls the rotation pipeline and raises full.
module vertex_perspective_projection_unit
    import vpp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic signed [WORLD_W-1:0] world_x,
    input  logic signed [WORLD_W-1:0] world_y,
    input  logic signed [WORLD_W-1:0] world_z,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [SCR_W-1:0]   screen_x,
    output logic signed [SCR_W-1:0]   screen_y,
    output logic [DEPTH_W-1:0]        depth_z,
    output logic                      saturated,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data
);

    cam_cfg_t         cfg_reg;
    cam_cfg_t         cfg_next;
    logic [FOC_W-1:0] focal_reg;
    logic [FOC_W-1:0] focal_next;

    logic  mq_wr;
    logic  mq_full;
    logic  mq_rd;
    logic  mq_empty;
    view_t mq_wr_data;
    view_t mq_rd_data;

    // Decode configuration writes
    always_comb
    begin
        cfg_next   = cfg_reg;
        focal_next = focal_reg;
        if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CAM_X: cfg_next.cam_x = cfg_data;
                REG_CAM_Y: cfg_next.cam_y = cfg_data;
                REG_CAM_Z: cfg_next.cam_z = cfg_data;
                REG_ROT_W: cfg_next.rot_w = cfg_data[ROT_W-1:0];
                REG_ROT_X: cfg_next.rot_x = cfg_data[ROT_W-1:0];
                REG_ROT_Y: cfg_next.rot_y = cfg_data[ROT_W-1:0];
                REG_ROT_Z: cfg_next.rot_z = cfg_data[ROT_W-1:0];
                REG_FOCAL: focal_next     = cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cam_x <= CAM_RESET;
            cfg_reg.cam_y <= CAM_RESET;
            cfg_reg.cam_z <= CAM_RESET;
            cfg_reg.rot_w <= ROT_W_RESET;
            cfg_reg.rot_x <= ROT_RESET;
            cfg_reg.rot_y <= ROT_RESET;
            cfg_reg.rot_z <= ROT_RESET;
            focal_reg     <= FOC_RESET;
        end
        else
        begin
            cfg_reg   <= cfg_next;
            focal_reg <= focal_next;
        end
    end

    vpp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .world_x (world_x),
        .world_y (world_y),
        .world_z (world_z),
        .cfg     (cfg_reg),
        .q_wr    (mq_wr),
        .q_data  (mq_wr_data),
        .q_full  (mq_full)
    );

    vpp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (mq_wr),
        .wr_data (mq_wr_data),
        .full    (mq_full),
        .rd      (mq_rd),
        .rd_data (mq_rd_data),
        .empty   (mq_empty)
    );

    vpp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (!mq_empty),
        .in_data   (mq_rd_data),
        .in_rd     (mq_rd),
        .focal     (focal_reg),
        .empty     (empty),
        .pop       (pop),
        .screen_x  (screen_x),
        .screen_y  (screen_y),
        .depth_z   (depth_z),
        .saturated (saturated)
    );

endmodule
